@@ hw/rtl/cszv_pkg.sv @@
// ----------------------------------------------------------------------------
// cszv_pkg
// shared types and constants of the compactsize varint codec
// ----------------------------------------------------------------------------
package cszv_pkg;

    localparam logic CMD_ENCODE = 1'b0;
    localparam logic CMD_DECODE = 1'b1;

    localparam logic [1:0] KIND_BYTE  = 2'd0;
    localparam logic [1:0] KIND_VALUE = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    localparam logic [7:0] MARK_16 = 8'hfd;
    localparam logic [7:0] MARK_32 = 8'hfe;
    localparam logic [7:0] MARK_64 = 8'hff;

    // total bytes of one encoded value, marker included
    localparam logic [3:0] LEN_1 = 4'd1;
    localparam logic [3:0] LEN_3 = 4'd3;
    localparam logic [3:0] LEN_5 = 4'd5;
    localparam logic [3:0] LEN_9 = 4'd9;

    // payload bytes after a marker
    localparam logic [3:0] GATHER_16 = 4'd2;
    localparam logic [3:0] GATHER_32 = 4'd4;
    localparam logic [3:0] GATHER_64 = 4'd8;

    typedef struct packed {
        logic [1:0]  kind;
        logic [3:0]  len;
        logic [63:0] payload;
    } entry_t;

endpackage

@@ hw/rtl/cszv_front.sv @@
// ----------------------------------------------------------------------------
// cszv_front
// accepts items, sizes encode values and runs the byte-wise decoder
// ----------------------------------------------------------------------------
module cszv_front
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            accept,
    input  logic            command,
    input  logic [63:0]     value_in,
    input  logic [7:0]      byte_in,
    input  logic            stream_end,
    output logic            push,
    output cszv_pkg::entry_t push_entry
);
    import cszv_pkg::*;

    logic        busy_reg, busy_next;
    logic [3:0]  left_reg, left_next;
    logic [2:0]  pos_reg, pos_next;
    logic [63:0] gath_reg, gath_next;

    logic [63:0] merged;
    logic [3:0]  left_dec;
    logic [3:0]  enc_len;
    logic [3:0]  gather_len;

    assign merged   = gath_reg | ({56'd0, byte_in} << {pos_reg, 3'b000});
    assign left_dec = left_reg - 4'd1;

    always_comb
    begin
        priority if (value_in < 64'(MARK_16))
            enc_len = LEN_1;
        else if (value_in[63:16] == 48'd0)
            enc_len = LEN_3;
        else if (value_in[63:32] == 32'd0)
            enc_len = LEN_5;
        else
            enc_len = LEN_9;
    end

    always_comb
    begin
        unique case (byte_in)
            MARK_16: gather_len = GATHER_16;
            MARK_32: gather_len = GATHER_32;
            default: gather_len = GATHER_64;
        endcase
    end

    always_comb
    begin
        busy_next          = busy_reg;
        left_next          = left_reg;
        pos_next           = pos_reg;
        gath_next          = gath_reg;
        push               = 1'b0;
        push_entry.kind    = KIND_BYTE;
        push_entry.len     = LEN_1;
        push_entry.payload = 64'd0;
        if (accept)
        begin
            if (command == CMD_ENCODE)
            begin
                push               = 1'b1;
                push_entry.len     = enc_len;
                push_entry.payload = value_in;
            end
            else if (!busy_reg)
            begin
                if (byte_in < MARK_16)
                begin
                    push               = 1'b1;
                    push_entry.kind    = KIND_VALUE;
                    push_entry.payload = {56'd0, byte_in};
                end
                else if (stream_end)
                begin
                    push            = 1'b1;
                    push_entry.kind = KIND_ERROR;
                end
                else
                begin
                    busy_next = 1'b1;
                    left_next = gather_len;
                    pos_next  = 3'd0;
                    gath_next = 64'd0;
                end
            end
            else
            begin
                if (left_dec == 4'd0)
                begin
                    push               = 1'b1;
                    push_entry.kind    = KIND_VALUE;
                    push_entry.payload = merged;
                    busy_next          = 1'b0;
                    left_next          = 4'd0;
                    pos_next           = 3'd0;
                    gath_next          = 64'd0;
                end
                else if (stream_end)
                begin
                    // value cut short by the end of the buffer
                    push            = 1'b1;
                    push_entry.kind = KIND_ERROR;
                    busy_next       = 1'b0;
                    left_next       = 4'd0;
                    pos_next        = 3'd0;
                    gath_next       = 64'd0;
                end
                else
                begin
                    left_next = left_dec;
                    pos_next  = pos_reg + 3'd1;
                    gath_next = merged;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            left_reg <= 4'd0;
            pos_reg  <= 3'd0;
            gath_reg <= 64'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            left_reg <= left_next;
            pos_reg  <= pos_next;
            gath_reg <= gath_next;
        end
    end

endmodule

@@ hw/rtl/cszv_queue.sv @@
// ----------------------------------------------------------------------------
// cszv_queue
// short fifo of work entries between front and back
// ----------------------------------------------------------------------------
module cszv_queue
#(
    parameter int DEPTH = 4
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  cszv_pkg::entry_t push_entry,
    input  logic             pop,
    output cszv_pkg::entry_t head,
    output logic             empty,
    output logic             full
);
    import cszv_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    entry_t            mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              do_push, do_pop;

    assign empty   = (count_reg == '0);
    assign full    = (count_reg == FULL_CNT);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (do_push && !do_pop)
            count_next = count_reg + CNT_W'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

@@ hw/rtl/cszv_back.sv @@
// ----------------------------------------------------------------------------
// cszv_back
// queue entries to registered result items, one per cycle when not stalled
// ----------------------------------------------------------------------------
module cszv_back
(
    input  logic             clk,
    input  logic             rst_n,
    input  cszv_pkg::entry_t head,
    input  logic             empty,
    output logic             pop,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [71:0]      m_tdata,
    output logic             m_tlast,
    output logic [1:0]       m_tuser
);
    import cszv_pkg::*;

    logic        valid_reg, valid_next;
    logic [3:0]  idx_reg, idx_next;
    logic [71:0] data_reg;
    logic        last_reg;
    logic [1:0]  kind_reg;

    logic        load, advance, is_last;
    logic [2:0]  sel;
    logic [7:0]  marker, enc_byte;
    logic [71:0] data_new;

    assign load    = !valid_reg || m_tready;
    assign advance = !empty && load;
    assign is_last = (idx_reg == head.len - 4'd1);
    assign pop     = advance && is_last;
    assign sel     = idx_reg[2:0] - 3'd1;

    always_comb
    begin
        unique case (head.len)
            LEN_3:   marker = MARK_16;
            LEN_5:   marker = MARK_32;
            default: marker = MARK_64;
        endcase
    end

    always_comb
    begin
        // byte zero is the marker unless the value fits one byte
        if (idx_reg == 4'd0)
            enc_byte = (head.len == LEN_1) ? head.payload[7:0] : marker;
        else
            enc_byte = head.payload[{sel, 3'b000} +: 8];
    end

    assign data_new = (head.kind == KIND_BYTE) ? {64'd0, enc_byte}
                                               : {head.payload, 8'd0};

    always_comb
    begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        if (load)
            valid_next = !empty;
        if (advance)
            idx_next = is_last ? 4'd0 : idx_reg + 4'd1;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            data_reg <= data_new;
            last_reg <= is_last;
            kind_reg <= head.kind;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= 4'd0;
        end
        else
        begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tlast  = last_reg;
    assign m_tuser  = kind_reg;

endmodule

@@ hw/rtl/compact_size_varint_codec.sv @@
// ----------------------------------------------------------------------------
// compact_size_varint_codec
// compactsize varint encoder and byte-wise decoder
// ----------------------------------------------------------------------------
// path: an accepted item is written into the queue, then loaded into the output register
// throughput: one result item per cycle at the output register, unless stalled;
//   a decode item gives at most one, an encode item one per byte (1, 3, 5 or 9)
// reset: asynchronous, clears the decoder state, the queue and the output valid
// ----------------------------------------------------------------------------
module compact_size_varint_codec
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // value_in [63:0], byte_in [71:64]
    input  logic        s_tlast,   // stream_end
    input  logic [0:0]  s_tuser,   // command
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // byte_out [7:0], value_out [71:8]
    output logic        m_tlast,   // last
    output logic [1:0]  m_tuser    // kind
);
    import cszv_pkg::*;

    logic   accept;
    logic   q_push, q_pop, q_empty, q_full;
    entry_t q_in, q_head;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    cszv_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .command    (s_tuser[0]),
        .value_in   (s_tdata[63:0]),
        .byte_in    (s_tdata[71:64]),
        .stream_end (s_tlast),
        .push       (q_push),
        .push_entry (q_in)
    );

    cszv_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_in),
        .pop        (q_pop),
        .head       (q_head),
        .empty      (q_empty),
        .full       (q_full)
    );

    cszv_back u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (q_head),
        .empty    (q_empty),
        .pop      (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("push into full queue");

    a_pop_data: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("pop from empty queue");

    a_error_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser == KIND_ERROR) |-> (m_tlast && m_tdata == 72'd0))
        else $error("error item not last or not zero");

    a_value_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser == KIND_VALUE) |-> (m_tlast && m_tdata[7:0] == 8'd0))
        else $error("decoded value item malformed");

endmodule
